FILE: rtl/masked_pixel_to_rgba8_assert.svh
// Assertion macros for the masked pixel unpacker.
// Plain text, no dependencies; included by the top level.
`ifndef MASKED_PIXEL_TO_RGBA8_ASSERT_SVH
`define MASKED_PIXEL_TO_RGBA8_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MPR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mpr_pkg.sv
// Package for the masked pixel unpacker: widths, register indexes, reset masks
// and the channel helper functions. No dependencies.
package mpr_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned OutW    = 8;
  localparam int unsigned NumChan = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned SizeW   = 6;

  localparam logic [OutW-1:0] OpaqueAlpha = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRed   = 2'd0,
    CfgGreen = 2'd1,
    CfgBlue  = 2'd2,
    CfgAlpha = 2'd3
  } cfg_idx_e;

  typedef logic [WordW-1:0] word_t;
  typedef logic [OutW-1:0]  chan_t;

  localparam word_t RedMaskRst   = 32'h00FF_0000;
  localparam word_t GreenMaskRst = 32'h0000_FF00;
  localparam word_t BlueMaskRst  = 32'h0000_00FF;
  localparam word_t AlphaMaskRst = 32'hFF00_0000;

  // Index of the set bit of a one-hot vector (zero for an all-zero vector).
  function automatic logic [SizeW-1:0] onehot_idx(logic [WordW:0] vec);
    logic [SizeW-1:0] idx;
    idx = '0;
    for (int i = 0; i <= WordW; i++) begin
      if (vec[i]) begin
        idx = idx | SizeW'(i);
      end
    end
    return idx;
  endfunction

  // Narrow or widen an aligned channel value to 8 bits; size is 1..32.
  function automatic chan_t expand_chan(word_t v, logic [SizeW-1:0] size);
    chan_t            res;
    chan_t            part;
    word_t            tail;
    logic [3:0]       rem;
    logic [SizeW-1:0] sh;
    res  = '0;
    rem  = 4'd8;
    part = '0;
    if (size >= SizeW'(OutW)) begin
      sh   = size - SizeW'(OutW);
      tail = v >> sh;
      res  = tail[OutW-1:0];
    end else begin
      for (int i = 0; i < OutW - 1; i++) begin
        if ({2'b00, rem} > size) begin
          part = v[OutW-1:0] << (rem - size[3:0]);
          res  = res | part;
          rem  = rem - size[3:0];
        end
      end
      sh   = size - {2'b00, rem};
      tail = v >> sh;
      res  = res | tail[OutW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/masked_pixel_to_rgba8.sv
// Masked pixel unpacker: packed pixel word to 8-bit red, green, blue, alpha.
// Depends on mpr_pkg and masked_pixel_to_rgba8_assert.svh.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------
//   in      | in_valid_i / in_stall_o  | pixel_word_i
//   out     | out_valid_o / out_stall_i| red_out_o green_out_o blue_out_o alpha_out_o
//   cfg     | cfg_we_i                 | cfg_idx_i cfg_wdata_i
//
// Three register stages, one pixel per cycle while the output is not stalled.
// Stage 1 masks the word and finds the lowest run edges, stage 2 encodes
// shift and size and aligns, stage 3 narrows or replicates to 8 bits.
// A stall holds the last stage; empty stages further up still fill.
// Reset clears the stage valids and loads the default masks.
module masked_pixel_to_rgba8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  `include "masked_pixel_to_rgba8_assert.svh"

  localparam int unsigned NC = mpr_pkg::NumChan;
  localparam int unsigned W  = mpr_pkg::WordW;

  mpr_pkg::word_t mask_q [NC];

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 1
  mpr_pkg::word_t   masked1_q [NC];
  mpr_pkg::word_t   low1_q    [NC];
  logic [W:0]       end1_q    [NC];
  // stage 2
  mpr_pkg::word_t            al2_q   [NC];
  logic [mpr_pkg::SizeW-1:0] size2_q [NC];
  logic [NC-1:0]             nz2_q;
  // stage 3
  mpr_pkg::chan_t out3_q [NC];

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q[mpr_pkg::CfgRed]   <= mpr_pkg::RedMaskRst;
      mask_q[mpr_pkg::CfgGreen] <= mpr_pkg::GreenMaskRst;
      mask_q[mpr_pkg::CfgBlue]  <= mpr_pkg::BlueMaskRst;
      mask_q[mpr_pkg::CfgAlpha] <= mpr_pkg::AlphaMaskRst;
    end else if (cfg_we_i) begin
      case (mpr_pkg::cfg_idx_e'(cfg_idx_i))
        mpr_pkg::CfgRed:   mask_q[mpr_pkg::CfgRed]   <= cfg_wdata_i;
        mpr_pkg::CfgGreen: mask_q[mpr_pkg::CfgGreen] <= cfg_wdata_i;
        mpr_pkg::CfgBlue:  mask_q[mpr_pkg::CfgBlue]  <= cfg_wdata_i;
        mpr_pkg::CfgAlpha: mask_q[mpr_pkg::CfgAlpha] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_chan
    mpr_pkg::word_t            low1_d;
    logic [W:0]                end1_d;
    logic [mpr_pkg::SizeW-1:0] shift2;
    logic [mpr_pkg::SizeW-1:0] end2;
    mpr_pkg::chan_t            out3_d;

    // lowest set bit, and the first clear bit above the lowest run
    assign low1_d = mask_q[c] & (~mask_q[c] + 1'b1);
    assign end1_d = ({1'b0, mask_q[c]} + {1'b0, low1_d}) & ~{1'b0, mask_q[c]};

    assign shift2 = mpr_pkg::onehot_idx({1'b0, low1_q[c]});
    assign end2   = mpr_pkg::onehot_idx(end1_q[c]);

    always_comb begin
      if (nz2_q[c]) begin
        out3_d = mpr_pkg::expand_chan(al2_q[c], size2_q[c]);
      end else if (c == int'(mpr_pkg::CfgAlpha)) begin
        out3_d = mpr_pkg::OpaqueAlpha;
      end else begin
        out3_d = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en1 && in_valid_i) begin
        masked1_q[c] <= pixel_word_i & mask_q[c];
        low1_q[c]    <= low1_d;
        end1_q[c]    <= end1_d;
      end
      if (en2 && v1_q) begin
        al2_q[c]   <= masked1_q[c] >> shift2[mpr_pkg::ShiftW-1:0];
        size2_q[c] <= end2 - shift2;
        nz2_q[c]   <= |low1_q[c];
      end
      if (en3 && v2_q) begin
        out3_q[c] <= out3_d;
      end
    end

    `MPR_ASSERT_NOW(a_run_edge_onehot, clk_i, rst_ni, v1_q && (|low1_q[c]),
      $onehot(end1_q[c]) && $onehot(low1_q[c]), "run edge vector not one-hot")
    `MPR_ASSERT_NOW(a_size_range, clk_i, rst_ni, v2_q && nz2_q[c],
      (size2_q[c] != '0) && (size2_q[c] <= mpr_pkg::SizeW'(W)), "run size out of range")
  end

  assign out_valid_o = v3_q;
  assign red_out_o   = out3_q[mpr_pkg::CfgRed];
  assign green_out_o = out3_q[mpr_pkg::CfgGreen];
  assign blue_out_o  = out3_q[mpr_pkg::CfgBlue];
  assign alpha_out_o = out3_q[mpr_pkg::CfgAlpha];

  `MPR_ASSERT_NOW(a_stall_full, clk_i, rst_ni, in_stall_o, v1_q && v2_q && v3_q,
    "input stalled with a bubble in the pipe")
  `MPR_ASSERT_NEXT(a_mid_hold, clk_i, rst_ni, v2_q && !en3, v2_q,
    "stalled middle beat dropped")

endmodule

FILE: verif/mpr_checker.sv
// Checker for the masked pixel unpacker: watches the pixel, result and mask-write ports,
// predicts each RGBA result from its own copy of the channel masks and compares in order.
// Depends on mpr_pkg.
module mpr_checker
  import mpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  word_t              pixel_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  chan_t              red_out_i,
  input  chan_t              green_out_i,
  input  chan_t              blue_out_i,
  input  chan_t              alpha_out_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  word_t              cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

  word_t chan_mask [NumChan];
  rgba_t rgba_due_q [$];
  rgba_t due_px;
  int    fail_count = 0;
  int    pending_cnt = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_cnt;

  // Lowest run of ones sets shift and size; bits above the run are kept.
  function automatic chan_t unpack_chan(word_t word, word_t mask);
    word_t       m;
    word_t       v;
    word_t       acc;
    int unsigned shift;
    int unsigned size;
    int unsigned left;
    if (mask == '0) begin
      return '0;
    end
    m     = mask;
    shift = 0;
    size  = 0;
    while (!m[0] && shift < 31) begin
      m = m >> 1;
      shift++;
    end
    while (m[0] && size < 32) begin
      m = m >> 1;
      size++;
    end
    v    = (word & mask) >> shift;
    acc  = '0;
    left = OutW;
    while (size < left) begin
      acc  = acc | (v << (left - size));
      left = left - size;
    end
    acc = acc | (v >> (size - left));
    return acc[OutW-1:0];
  endfunction

  function automatic rgba_t predict_rgba(word_t word);
    rgba_t px;
    px.red   = unpack_chan(word, chan_mask[CfgRed]);
    px.green = unpack_chan(word, chan_mask[CfgGreen]);
    px.blue  = unpack_chan(word, chan_mask[CfgBlue]);
    px.alpha = (chan_mask[CfgAlpha] == '0) ? OpaqueAlpha
                                          : unpack_chan(word, chan_mask[CfgAlpha]);
    return px;
  endfunction

  task automatic check_chan(input string name, input chan_t want, input chan_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_mask[CfgRed]   <= RedMaskRst;
      chan_mask[CfgGreen] <= GreenMaskRst;
      chan_mask[CfgBlue]  <= BlueMaskRst;
      chan_mask[CfgAlpha] <= AlphaMaskRst;
    end else if (cfg_we_i) begin
      chan_mask[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgba_due_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rgba_due_q.size() == 0) begin
          $error("result beat with no pixel outstanding");
          fail_count++;
        end else begin
          due_px = rgba_due_q.pop_front();
          check_chan("red_out", due_px.red, red_out_i);
          check_chan("green_out", due_px.green, green_out_i);
          check_chan("blue_out", due_px.blue, blue_out_i);
          check_chan("alpha_out", due_px.alpha, alpha_out_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rgba_due_q.push_back(predict_rgba(pixel_word_i));
      end
    end
    pending_cnt = rgba_due_q.size();
  end

endmodule

FILE: verif/tb_masked_pixel_to_rgba8.sv
// Testbench top for masked_pixel_to_rgba8: reset, mask writes, pixel stimulus with
// random idling on both sides, and the verdict. Checking sits in mpr_checker.
// Depends on mpr_pkg, mpr_checker and the block itself.
module tb_masked_pixel_to_rgba8;
  timeunit 1ns;
  timeprecision 1ps;
  import mpr_pkg::*;

  logic     clk_i        = 1'b0;
  logic     rst_ni       = 1'b0;
  logic     in_valid_i   = 1'b0;
  logic     in_stall_o;
  word_t    pixel_word_i = '0;
  logic     out_valid_o;
  logic     out_stall_i  = 1'b0;
  chan_t    red_out_o;
  chan_t    green_out_o;
  chan_t    blue_out_o;
  chan_t    alpha_out_o;
  logic     cfg_we_i     = 1'b0;
  cfg_idx_e cfg_idx_i    = CfgRed;
  word_t    cfg_wdata_i  = '0;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;

  always #5ns clk_i = ~clk_i;

  masked_pixel_to_rgba8 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_word_i (pixel_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  mpr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .pixel_word_i (pixel_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_i    (red_out_o),
    .green_out_i  (green_out_o),
    .blue_out_i   (blue_out_o),
    .alpha_out_i  (alpha_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Stall is sampled mid-cycle so the beat decision never races the edge.
  task automatic send_pixel(input word_t word);
    logic stalled;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_word_i <= word;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_masks(input word_t red, input word_t green, input word_t blue,
                             input word_t alpha);
    word_t vals [NumChan];
    vals[CfgRed]   = red;
    vals[CfgGreen] = green;
    vals[CfgBlue]  = blue;
    vals[CfgAlpha] = alpha;
    drain_results();
    for (int i = 0; i < NumChan; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic word_t run_mask(int unsigned sh, int unsigned sz);
    if (sz >= WordW) begin
      return '1;
    end
    return ((word_t'(1) << sz) - word_t'(1)) << sh;
  endfunction

  function automatic word_t draw_mask();
    int unsigned sh;
    int unsigned sz;
    sh = $urandom_range(0, WordW - 1);
    sz = $urandom_range(0, 1) ? $urandom_range(1, (WordW - sh < 8) ? WordW - sh : 8)
                              : $urandom_range(1, WordW - sh);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      6, 7:    return run_mask(sh, sz) | run_mask($urandom_range(0, 31), $urandom_range(1, 4));
      8, 9:    return $urandom;
      default: return run_mask(sh, sz);
    endcase
  endfunction

  function automatic word_t draw_pixel();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return $urandom & $urandom;
      3:       return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct  = 28;
    stall_pct = 78;

    // default masks after reset
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    send_pixel(32'h80FF_017F);

    // all masks clear: colours zero, alpha opaque
    write_masks('0, '0, '0, '0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);

    // narrow channels of every width from one to seven, top bit alone for alpha
    write_masks(32'h0000_0001, 32'h0000_0006, 32'h0000_0038, 32'h0000_03C0);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hAAAA_AAAA);
    send_pixel(32'h5555_5555);
    write_masks(32'h0000_7C00, 32'h001F_8000, 32'h0FE0_0000, 32'h8000_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hAAAA_AAAA);
    send_pixel(32'h5555_5555);

    // full-width mask, masks with gaps above the lowest run, wide alpha
    write_masks(32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_F0F0, 32'h0001_FFFE);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    send_pixel(32'hDEAD_BEEF);

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0:       begin idle_pct = 28; stall_pct = 78; end
        1:       begin idle_pct = 78; stall_pct = 28; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      for (int set = 0; set < 8; set++) begin
        write_masks(draw_mask(), draw_mask(), draw_mask(), draw_mask());
        for (int n = 0; n < 70; n++) begin
          send_pixel(draw_pixel());
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_masked_pixel_to_rgba8: done, clean");
    end else begin
      $display("tb_masked_pixel_to_rgba8: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000ns;
    $display("tb_masked_pixel_to_rgba8: done, errors");
    $finish;
  end

endmodule

FILE: masked_pixel_to_rgba8.f
+incdir+rtl
rtl/mpr_pkg.sv
rtl/masked_pixel_to_rgba8.sv
verif/mpr_checker.sv
verif/tb_masked_pixel_to_rgba8.sv
